>>> rtl/b64c_pkg.sv
// ----------------------------------------------------------------------------
// b64c_pkg: shared types, constants and symbol mapping for the codec
// Group word layout between front and back, last-symbol positions, and the
// alphabet mapping in both directions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b64c_pkg;

    localparam int GROUP_W = 24;

    // front: fill count at which the incoming item completes a group
    localparam logic [1:0] ENC_FULL_FILL = 2'd2;
    localparam logic [1:0] DEC_FULL_FILL = 2'd3;

    // back: symbol position of the last result in a group
    localparam logic [1:0] ENC_LAST_IDX = 2'd3;
    localparam logic [1:0] DEC_LAST_IDX = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_LOW_A = 8'h61;  // 'a'
    localparam logic [7:0] CH_LOW_Z = 8'h7a;  // 'z'
    localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
    localparam logic [7:0] CH_UP_Z  = 8'h5a;  // 'Z'
    localparam logic [7:0] CH_PLUS  = 8'h2b;  // '+'
    localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'

    localparam logic [5:0] IDX_DIGITS = 6'd10;
    localparam logic [5:0] IDX_PLUS   = 6'd62;
    localparam logic [5:0] IDX_MINUS  = 6'd63;

    typedef struct packed {
        logic [GROUP_W-1:0] bits;
        logic               decode;
        logic               bad;
    } t_group;

    // 6-bit index to alphabet character; letters interleave lower, upper
    function automatic logic [7:0] enc_char(input logic [5:0] idx);
        logic [5:0] off;
        logic [7:0] ch;
        off = idx - IDX_DIGITS;
        if (idx < IDX_DIGITS) begin
            ch = CH_ZERO + {2'b00, idx};
        end else if (idx < IDX_PLUS) begin
            ch = (off[0] ? CH_UP_A : CH_LOW_A) + {3'b000, off[5:1]};
        end else if (idx == IDX_PLUS) begin
            ch = CH_PLUS;
        end else begin
            ch = CH_MINUS;
        end
        return ch;
    endfunction

    // character to {bad, index}; a character outside the alphabet gives index 0
    function automatic logic [6:0] dec_index(input logic [7:0] c);
        logic [7:0] d;
        logic [6:0] r;
        d = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
            r = {1'b0, d[5:0]};
        end else if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            d = c - CH_LOW_A;
            r = {1'b0, d[4:0], 1'b0} + {1'b0, IDX_DIGITS};
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = c - CH_UP_A;
            r = {1'b0, d[4:0], 1'b1} + {1'b0, IDX_DIGITS};
        end else if (c == CH_PLUS) begin
            r = {1'b0, IDX_PLUS};
        end else if (c == CH_MINUS) begin
            r = {1'b0, IDX_MINUS};
        end else begin
            r = 7'b100_0000;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/b64c_front.sv
// ----------------------------------------------------------------------------
// b64c_front: input gather stage
// Accepts words, maps characters in decode mode, gathers a group and pushes
// the finished group to the queue. Holds the mode register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64c_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_in_byte,
    input  wire logic            i_end_of_string,
    input  wire logic            i_cfg_valid,
    input  wire logic            i_cfg_data,
    output logic                 o_decode_mode,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output b64c_pkg::t_group     o_group
);
    import b64c_pkg::*;

    logic               r_mode,  n_mode;
    logic [GROUP_W-1:0] r_bits,  n_bits;
    logic [1:0]         r_fill,  n_fill;
    logic               r_bad,   n_bad;

    logic [6:0]         dec;
    logic               completes;
    logic               accept;
    logic [GROUP_W-1:0] merged_bits;
    logic               merged_bad;

    always_comb begin
        dec         = dec_index(i_in_byte);
        completes   = r_mode ? (r_fill == DEC_FULL_FILL) : (r_fill == ENC_FULL_FILL);
        // only a completing word needs queue space; a mode write holds off input
        o_ready     = (!i_q_full || !completes) && !i_cfg_valid;
        accept      = i_valid && o_ready;
        merged_bits = r_mode ? {r_bits[GROUP_W-7:0], dec[5:0]}
                             : {r_bits[GROUP_W-9:0], i_in_byte};
        merged_bad  = r_mode && (r_bad || dec[6]);

        o_push         = accept && completes;
        o_group.bits   = merged_bits;
        o_group.decode = r_mode;
        o_group.bad    = merged_bad;
        o_decode_mode  = r_mode;

        n_mode = r_mode;
        n_bits = r_bits;
        n_fill = r_fill;
        n_bad  = r_bad;
        if (i_cfg_valid) begin
            n_mode = i_cfg_data;
            n_bits = '0;
            n_fill = '0;
            n_bad  = 1'b0;
        end else if (accept) begin
            if (completes || i_end_of_string) begin
                n_bits = '0;
                n_fill = '0;
                n_bad  = 1'b0;
            end else begin
                n_bits = merged_bits;
                n_fill = r_fill + 2'd1;
                n_bad  = merged_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_bits <= '0;
            r_fill <= '0;
            r_bad  <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_bits <= n_bits;
            r_fill <= n_fill;
            r_bad  <= n_bad;
        end
    end

endmodule

`default_nettype wire

>>> rtl/b64c_queue.sv
// ----------------------------------------------------------------------------
// b64c_queue: two-entry group queue
// Decouples the gather stage from the output serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64c_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire b64c_pkg::t_group i_group,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output b64c_pkg::t_group      o_group
);
    import b64c_pkg::*;

    t_group      r_mem [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count,  n_count;

    always_comb begin
        o_full   = (r_count == 2'd2);
        o_valid  = (r_count != 2'd0);
        o_group  = r_mem[r_rd_ptr];
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop  ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

endmodule

`default_nettype wire

>>> rtl/b64c_back.sv
// ----------------------------------------------------------------------------
// b64c_back: output serializer
// Takes a group from the queue and emits its characters or bytes one word
// per cycle while not stalled by i_ready, through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64c_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire b64c_pkg::t_group i_group,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_run_last,
    output logic                  o_bad_symbol
);
    import b64c_pkg::*;

    logic               r_busy,      n_busy;
    logic [1:0]         r_idx,       n_idx;
    logic               r_out_valid, n_out_valid;
    logic [GROUP_W-1:0] r_word;
    logic               r_decode;
    logic               r_bad;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic               r_out_bad;

    logic               can_emit;
    logic               emit;
    logic               is_last;
    logic [5:0]         enc_six;
    logic [7:0]         dec_byte;
    logic [7:0]         sym;

    always_comb begin
        can_emit = !r_out_valid || i_ready;
        emit     = r_busy && can_emit;
        is_last  = r_decode ? (r_idx == DEC_LAST_IDX) : (r_idx == ENC_LAST_IDX);
        // load the next group as the current one hands out its last word
        o_pop    = i_q_valid && (!r_busy || (emit && is_last));

        case (r_idx)
            2'd0: begin
                enc_six  = r_word[23:18];
                dec_byte = r_word[23:16];
            end
            2'd1: begin
                enc_six  = r_word[17:12];
                dec_byte = r_word[15:8];
            end
            2'd2: begin
                enc_six  = r_word[11:6];
                dec_byte = r_word[7:0];
            end
            default: begin
                enc_six  = r_word[5:0];
                dec_byte = r_word[7:0];
            end
        endcase
        sym = r_decode ? dec_byte : enc_char(enc_six);

        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end

        n_busy = r_busy;
        n_idx  = emit ? r_idx + 2'd1 : r_idx;
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end else if (emit && is_last) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word   <= i_group.bits;
            r_decode <= i_group.decode;
            r_bad    <= i_group.bad;
        end
        if (emit) begin
            r_out_byte <= sym;
            r_out_last <= is_last;
            r_out_bad  <= r_bad;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_run_last   = r_out_last;
    assign o_bad_symbol = r_out_bad;

endmodule

`default_nettype wire

>>> rtl/base64_style_codec.sv
// ----------------------------------------------------------------------------
// base64_style_codec: streaming base64-style encoder / decoder
// Gather stage, two-entry group queue and output serializer.
// Path: the group completed by an accepted word is written to the queue, then
//   loaded into the serializer word register and registered at the output.
// Throughput: one output word per cycle from the serializer while not stalled;
//   decode takes 1 input word per cycle, encode 3 input words per 4 outputs.
// Reset: synchronous; mode returns to encode, partial group, queue and output
//   stage are cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module base64_style_codec (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_end_of_string,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_bad_symbol,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data
);
    import b64c_pkg::*;

    t_group  front_group;
    t_group  q_group;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_valid;
    logic    decode_mode;

    assign o_cfg_ready = 1'b1;

    b64c_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_decode_mode   (decode_mode),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_group         (front_group)
    );

    b64c_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_group (front_group),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_group (q_group)
    );

    b64c_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_group      (q_group),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_bad_symbol (o_bad_symbol)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("group pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("group popped from empty queue");

    a_bad_only_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_symbol |-> decode_mode)
        else $error("bad symbol flag in encode mode");

    a_encode_group_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push && !front_group.decode |-> !front_group.bad)
        else $error("encode group carries bad flag");
`endif

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for base64_style_codec
// Drives byte/character words in encode and decode mode under varying
// backpressure, predicts every output word of each completed group and
// compares them in order against the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class codec_scoreboard;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } t_out_word;

    // symbol table, index 0 in the top byte
    localparam logic [511:0] SYMBOLS =
        "0123456789aAbBcCdDeEfFgGhHiIjJkKlLmMnNoOpPqQrRsStTuUvVwWxXyYzZ+-";
    localparam int MAX_PRINTS = 30;

    t_out_word   out_words_q[$];
    logic        decode_mode;
    logic [23:0] group_bits;
    logic [1:0]  group_fill;
    logic        group_bad;
    int          errors;
    int          n_inputs;
    int          n_results;
    int          n_bad_groups;

    function new();
        decode_mode  = 1'b0;
        errors       = 0;
        n_inputs     = 0;
        n_results    = 0;
        n_bad_groups = 0;
        clear_group();
    endfunction

    function logic [7:0] char_of(int idx);
        return SYMBOLS[8*(63-idx) +: 8];
    endfunction

    // {miss, index}; miss set when the character is not a symbol
    function logic [6:0] index_of(logic [7:0] c);
        for (int i = 0; i < 64; i++) begin
            if (char_of(i) == c) begin
                return {1'b0, 6'(i)};
            end
        end
        return 7'h40;
    endfunction

    function void clear_group();
        group_bits = '0;
        group_fill = '0;
        group_bad  = 1'b0;
    endfunction

    function void set_mode(logic m);
        decode_mode = m;
        clear_group();
    endfunction

    function int pending();
        return out_words_q.size();
    endfunction

    function void take_input(logic [7:0] b, logic eos);
        logic [6:0] hit;
        t_out_word  w;
        n_inputs++;
        if (!decode_mode) begin
            group_bits = {group_bits[15:0], b};
            if (group_fill == 2'd2) begin
                for (int k = 0; k < 4; k++) begin
                    w.data = char_of(int'(group_bits[(18-6*k) +: 6]));
                    w.last = (k == 3);
                    w.bad  = 1'b0;
                    out_words_q.push_back(w);
                end
                clear_group();
            end else begin
                group_fill++;
            end
        end else begin
            hit = index_of(b);
            if (hit[6]) begin
                group_bad = 1'b1;
            end
            group_bits = {group_bits[17:0], hit[5:0]};
            if (group_fill == 2'd3) begin
                for (int k = 0; k < 3; k++) begin
                    w.data = group_bits[(16-8*k) +: 8];
                    w.last = (k == 2);
                    w.bad  = group_bad;
                    out_words_q.push_back(w);
                end
                if (group_bad) begin
                    n_bad_groups++;
                end
                clear_group();
            end else begin
                group_fill++;
            end
        end
        if (eos) begin
            clear_group();
        end
    endfunction

    task report(string what, int got, int want);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     n_results, what, got, want);
        end
    endtask

    task check_result(logic [7:0] data, logic last, logic bad);
        t_out_word w;
        if (out_words_q.size() == 0) begin
            report("unexpected word, out_byte", data, 0);
            return;
        end
        w = out_words_q.pop_front();
        if (data !== w.data) report("out_byte", data, w.data);
        if (last !== w.last) report("run_last", last, w.last);
        if (bad !== w.bad) report("bad_symbol", bad, w.bad);
        n_results++;
    endtask

endclass

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_end_of_string = 1'b0;
    logic       i_ready = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_data = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_bad_symbol;
    logic       o_cfg_ready;

    int send_idle = 0;
    int recv_idle = 0;
    int n_mode_writes = 0;

    codec_scoreboard sb = new();

    base64_style_codec u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last),
        .o_bad_symbol    (o_bad_symbol),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.take_input(i_in_byte, i_end_of_string);
            if (o_valid && i_ready) sb.check_result(o_out_byte, o_run_last, o_bad_symbol);
        end
    end

    // quiet-cycle watchdog
    initial begin
        int quiet;
        quiet = 0;
        @(posedge i_rst_n);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                 WATCHDOG_LIMIT, sb.pending());
        $display("FAILED: results differ");
        $finish;
    end

    // called at an edge; returns at the edge that accepts the word
    task send_word(logic [7:0] b, logic eos);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_in_byte       <= b;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // hold the sender until every predicted word has come out
    task drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_mode(logic m);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_mode(m);
        n_mode_writes++;
    endtask

    task random_word(logic m);
        logic [7:0] b;
        if (m && $urandom_range(9) != 0)
            b = sb.char_of($urandom_range(63));
        else
            b = 8'($urandom_range(255));
        send_word(b, $urandom_range(11) == 0);
    endtask

    initial begin
        int seg_len;
        int prof;
        logic m;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle = 21;
        recv_idle = 77;

        // encode: all-zero and all-one groups, dropped tail, end on a full group
        write_mode(1'b0);
        send_word(8'h00, 1'b0); send_word(8'h00, 1'b0); send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0); send_word(8'hff, 1'b0); send_word(8'hff, 1'b0);
        send_word(8'h12, 1'b0); send_word(8'h34, 1'b1);
        send_word(8'ha5, 1'b0); send_word(8'h5a, 1'b0); send_word(8'hc3, 1'b1);
        // partial group left behind; the mode switch must discard it
        send_word(8'h7e, 1'b0); send_word(8'h81, 1'b0);
        drain();

        // decode: edge symbols, unknown characters, dropped tail
        write_mode(1'b1);
        send_word("-", 1'b0); send_word("Z", 1'b0); send_word("+", 1'b0);
        send_word("0", 1'b0);
        send_word(8'h00, 1'b0); send_word("9", 1'b0); send_word("z", 1'b0);
        send_word(8'hff, 1'b0);
        send_word("A", 1'b1);
        send_word("y", 1'b0); send_word("Y", 1'b0); send_word("!", 1'b0);
        send_word("q", 1'b1);
        drain();

        // random segments: three idle profiles, each in both modes
        for (int seg = 0; seg < 6; seg++) begin
            prof = seg / 2;
            m    = seg[0];
            send_idle = (prof == 0) ? 21 : (prof == 1) ? 77 : 0;
            recv_idle = (prof == 0) ? 77 : (prof == 1) ? 21 : 0;
            write_mode(m);
            seg_len = $urandom_range(46, 56);
            for (int i = 0; i < seg_len; i++) begin
                if (i == seg_len / 2) drain();
                random_word(m);
            end
            drain();
        end

        $display("covered %0d input words, %0d output words checked, %0d mode writes",
                 sb.n_inputs, sb.n_results, n_mode_writes);
        $display("decode groups flagged for unknown characters: %0d, errors: %0d",
                 sb.n_bad_groups, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
